/* rtl/mvfb_pkg.sv */
`default_nettype none

package mvfb_pkg;

  // Input item kinds (s_tuser)
  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // Configuration register indexes
  localparam logic CFG_SYSTEM_ID    = 1'b0;
  localparam logic CFG_COMPONENT_ID = 1'b1;

  localparam logic [7:0]  FRAME_MAGIC        = 8'hFD;
  localparam logic [15:0] CHECK_INIT         = 16'hFFFF;
  localparam logic [7:0]  SYSTEM_ID_RESET    = 8'd1;
  localparam logic [7:0]  COMPONENT_ID_RESET = 8'd191;

  // One unit of work handed from the framer to the serializer
  typedef struct packed {
    logic        hdr;          // 1: header job, 0: single payload byte
    logic        fin;          // append the check bytes after this job
    logic [7:0]  seed;         // CRC-extra folded in before the check
    logic [7:0]  len;
    logic [7:0]  seq;
    logic [7:0]  sys_id;
    logic [7:0]  comp_id;
    logic [23:0] msg_id;
    logic [7:0]  data;
  } job_t;

  // One byte step of CRC-16/MCRF4XX
  function automatic logic [15:0] check_fold(input logic [15:0] c, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ c[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, c[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

`default_nettype wire

/* rtl/mvfb_framer.sv */
`default_nettype none

// Frame bookkeeping and configuration; turns accepted items into jobs.
module mvfb_framer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_addr,
  input  wire logic [7:0]        cfg_wdata,
  input  wire logic              accept,
  input  wire logic              kind,
  input  wire logic [23:0]       message_id,
  input  wire logic [7:0]        payload_length,
  input  wire logic [7:0]        extra_seed,
  input  wire logic [7:0]        data_byte,
  input  wire logic              job_pop,
  output mvfb_pkg::job_t         job,
  output logic                   job_valid,
  output logic                   ready
);

  logic [7:0] sys_id;
  logic [7:0] comp_id;
  logic [7:0] seq;
  logic [7:0] bytes_left;
  logic [7:0] held_seed;
  logic       in_frame;

  logic       is_start;
  logic       is_data;
  logic       data_fin;

  assign ready    = !job_valid || job_pop;
  assign is_start = accept && (kind == mvfb_pkg::KIND_START);
  assign is_data  = accept && (kind == mvfb_pkg::KIND_PAYLOAD) && in_frame;
  assign data_fin = (bytes_left == 8'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sys_id  <= mvfb_pkg::SYSTEM_ID_RESET;
      comp_id <= mvfb_pkg::COMPONENT_ID_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        mvfb_pkg::CFG_SYSTEM_ID:    sys_id  <= cfg_wdata;
        mvfb_pkg::CFG_COMPONENT_ID: comp_id <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq        <= 8'd0;
      bytes_left <= 8'd0;
      held_seed  <= 8'd0;
      in_frame   <= 1'b0;
      job_valid  <= 1'b0;
    end else begin
      if (is_start) begin
        seq        <= seq + 8'd1;
        bytes_left <= payload_length;
        held_seed  <= extra_seed;
        in_frame   <= (payload_length != 8'd0);
      end else if (is_data) begin
        bytes_left <= bytes_left - 8'd1;
        in_frame   <= !data_fin;
      end
      if (is_start || is_data) begin
        job_valid <= 1'b1;
      end else if (job_pop) begin
        job_valid <= 1'b0;
      end
    end
  end

  // Job payload, no reset needed
  always_ff @(posedge clk) begin
    if (is_start) begin
      job.hdr     <= 1'b1;
      job.fin     <= (payload_length == 8'd0);
      job.seed    <= extra_seed;
      job.len     <= payload_length;
      job.seq     <= seq;
      job.sys_id  <= sys_id;
      job.comp_id <= comp_id;
      job.msg_id  <= message_id;
      job.data    <= data_byte;
    end else if (is_data) begin
      job.hdr  <= 1'b0;
      job.fin  <= data_fin;
      job.seed <= held_seed;
      job.data <= data_byte;
    end
  end

endmodule

`default_nettype wire

/* rtl/mvfb_serializer.sv */
`default_nettype none

// Walks a job out one byte per cycle unless stalled, folds check, registers m_*.
module mvfb_serializer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mvfb_pkg::job_t    job,
  input  wire logic              job_valid,
  output logic                   job_pop,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [7:0]             m_tdata,
  output logic                   m_tlast
);

  // Byte positions within a job
  localparam logic [3:0] POS_MAGIC   = 4'd0;
  localparam logic [3:0] POS_LEN     = 4'd1;
  localparam logic [3:0] POS_INCOMPAT = 4'd2;
  localparam logic [3:0] POS_COMPAT  = 4'd3;
  localparam logic [3:0] POS_SEQ     = 4'd4;
  localparam logic [3:0] POS_SYS     = 4'd5;
  localparam logic [3:0] POS_COMP    = 4'd6;
  localparam logic [3:0] POS_MID0    = 4'd7;
  localparam logic [3:0] POS_MID1    = 4'd8;
  localparam logic [3:0] POS_MID2    = 4'd9;
  localparam logic [3:0] POS_DATA    = 4'd10;
  localparam logic [3:0] POS_CRC_LO  = 4'd11;
  localparam logic [3:0] POS_CRC_HI  = 4'd12;

  logic        active;
  logic [3:0]  pos;
  logic [15:0] crc;

  logic [3:0]  cur_pos;
  logic [7:0]  cur_byte;
  logic [7:0]  fold_in;
  logic [15:0] crc_fold;
  logic        step;
  logic        job_last;

  assign step    = job_valid && (!m_tvalid || m_tready);
  assign cur_pos = active ? pos : (job.hdr ? POS_MAGIC : POS_DATA);
  assign fold_in = (cur_pos == POS_CRC_LO) ? job.seed : cur_byte;
  assign crc_fold = mvfb_pkg::check_fold(crc, fold_in);

  always_comb begin
    case (cur_pos)
      POS_MAGIC:    cur_byte = mvfb_pkg::FRAME_MAGIC;
      POS_LEN:      cur_byte = job.len;
      POS_INCOMPAT: cur_byte = 8'h00;
      POS_COMPAT:   cur_byte = 8'h00;
      POS_SEQ:      cur_byte = job.seq;
      POS_SYS:      cur_byte = job.sys_id;
      POS_COMP:     cur_byte = job.comp_id;
      POS_MID0:     cur_byte = job.msg_id[7:0];
      POS_MID1:     cur_byte = job.msg_id[15:8];
      POS_MID2:     cur_byte = job.msg_id[23:16];
      POS_DATA:     cur_byte = job.data;
      POS_CRC_LO:   cur_byte = crc_fold[7:0];
      POS_CRC_HI:   cur_byte = crc[15:8];
      default:      cur_byte = 8'h00;
    endcase
  end

  assign job_last = (cur_pos == POS_CRC_HI) ||
                    (((cur_pos == POS_MID2) || (cur_pos == POS_DATA)) && !job.fin);
  assign job_pop  = step && job_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      pos      <= POS_MAGIC;
      crc      <= mvfb_pkg::CHECK_INIT;
      m_tvalid <= 1'b0;
    end else begin
      if (step) begin
        active <= !job_last;
        if ((cur_pos == POS_MID2) || (cur_pos == POS_DATA)) begin
          pos <= POS_CRC_LO;
        end else begin
          pos <= cur_pos + 4'd1;
        end
        if (cur_pos == POS_MAGIC || cur_pos == POS_CRC_HI) begin
          crc <= mvfb_pkg::CHECK_INIT;
        end else begin
          crc <= crc_fold;
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= cur_byte;
      m_tlast <= (cur_pos == POS_CRC_HI);
    end
  end

endmodule

`default_nettype wire

/* rtl/mavlink_v2_frame_builder.sv */
`default_nettype none

// MAVLink v2 frame builder.
// Slave channel (s_*): one item per handshake. s_tuser = 0 is a start item
// (message id, payload length, CRC-extra); s_tuser = 1 is one payload byte.
// Master channel (m_*): the frame as a byte stream, one byte per item;
// m_tlast marks the CRC high byte that closes a frame.
// Config port: cfg_wr_en/cfg_addr/cfg_wdata; index 0 system id, 1 component id.
// An accepted item is registered in the job register, then its first byte in
// the output register. Throughput: one output byte per cycle unless m_tready
// stalls. A start item holds the serializer for its ten header bytes, a payload
// byte for itself; either adds both CRC bytes when it closes the frame. s_tready
// is high whenever the one-entry job register is free or its job sends its final
// byte this cycle, so unstalled payload bytes stream back to back, one per cycle.
// Payload bytes outside a frame are dropped; a start abandons an open frame.
// Reset (rst, synchronous) empties both stages, restores the config defaults
// (1 and 191), zeroes the sequence number and closes any frame.
// When the receiver stalls, the output register holds its byte, the job
// register fills, and s_tready drops until the stream moves again.
module mavlink_v2_frame_builder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_addr,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [23:0] message_id, [31:24] payload_length, [39:32] extra_seed, [47:40] data_byte
  input  wire logic [47:0] s_tdata,
  // [0] kind
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] out_byte
  output logic [7:0]       m_tdata,
  // frame_end
  output logic             m_tlast
);

  mvfb_pkg::job_t job;
  logic           job_valid;
  logic           job_pop;
  logic           accept;

  assign accept = s_tvalid && s_tready;

  mvfb_framer u_framer (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .accept         (accept),
    .kind           (s_tuser),
    .message_id     (s_tdata[23:0]),
    .payload_length (s_tdata[31:24]),
    .extra_seed     (s_tdata[39:32]),
    .data_byte      (s_tdata[47:40]),
    .job_pop        (job_pop),
    .job            (job),
    .job_valid      (job_valid),
    .ready          (s_tready)
  );

  mvfb_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

/* rtl/mvfb_checker.sv */
`default_nettype none

module mvfb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);

  // Output byte must not vanish while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output item dropped while stalled");

  // Stalled output keeps its byte and its end mark
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("output item changed while stalled");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // Input is held off only while a job is queued, which keeps the output busy
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> m_tvalid)
    else $error("input stalled with no output pending");

endmodule

bind mavlink_v2_frame_builder mvfb_checker u_mvfb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
